/* design/mpa_pkg.sv */
package mpa_pkg;

  localparam int VALUE_W       = 16;
  localparam int INDEX_W       = 26;
  localparam int MAX_OUT_WIDTH = 1024;
  localparam int MAX_OUTPUTS   = 16384;
  localparam int COL_AW        = $clog2(MAX_OUT_WIDTH);
  localparam int ARG_AW        = $clog2(MAX_OUTPUTS);
  localparam int POS_W         = ARG_AW + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W      = 7;
  localparam int DIM_W      = 11;
  localparam int WIN_W      = 4;
  localparam int CH_W       = 6;
  localparam int RC_W       = 10;
  localparam int PX_W       = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd3;

  localparam logic OP_FORWARD  = 1'b0;
  localparam logic OP_BACKWARD = 1'b1;

  localparam logic KIND_MAX  = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  // clamped geometry and gradient pass length
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic [WIN_W-1:0] win;
    logic [POS_W-1:0] pass_len;
  } cfg_t;

  // classified item travelling from front to back
  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic [COL_AW-1:0]         col;
    logic [ARG_AW-1:0]         arg_addr;
    logic                      arg_ok;
    logic                      px_first;
    logic                      px_last;
    logic                      py_first;
    logic                      py_last;
    logic                      last;
  } item_t;

endpackage

/* design/mpa_in_if.sv */
interface mpa_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic signed [mpa_pkg::VALUE_W-1:0] sample_value;

  modport source (output valid, output opcode, output sample_value, input ready);
  modport sink (input valid, input opcode, input sample_value, output ready);
endinterface

/* design/mpa_out_if.sv */
interface mpa_out_if;
  logic                               valid;
  logic                               ready;
  logic                               result_kind;
  logic signed [mpa_pkg::VALUE_W-1:0] result_value;
  logic [mpa_pkg::INDEX_W-1:0]        input_index;
  logic                               pass_end;

  modport source (output valid, output result_kind, output result_value,
                  output input_index, output pass_end, input ready);
  modport sink (input valid, input result_kind, input result_value,
                input input_index, input pass_end, output ready);
endinterface

/* design/mpa_cfg.sv */
module mpa_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output mpa_pkg::cfg_t                  cfg,
  output logic                           settling
);
  import mpa_pkg::*;

  localparam int RECIP_SHIFT   = 16;
  localparam int RECIP_W       = RECIP_SHIFT + 1;
  localparam int PROD_W        = DIM_W + RECIP_W;
  localparam int ROWS_W        = CNT_W + DIM_W;
  localparam int PASS_W        = ROWS_W + DIM_W;
  localparam int SETTLE_CYCLES = 4;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  // ceil(2^16 / s); exact floor division for heights up to 1024
  function automatic logic [RECIP_W-1:0] recip(input logic [WIN_W-1:0] s);
    logic [RECIP_W-1:0] r;
    case (s)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd8192;
    endcase
    return r;
  endfunction

  logic [CNT_W-1:0]    channel_count;
  logic [DIM_W-1:0]    frame_height;
  logic [DIM_W-1:0]    frame_width;
  logic [WIN_W-1:0]    window_size;
  logic [CNT_W-1:0]    cl_count;
  logic [DIM_W-1:0]    cl_height;
  logic [DIM_W-1:0]    cl_width;
  logic [WIN_W-1:0]    cl_win;
  logic [DIM_W-1:0]    out_rows;
  logic [DIM_W-1:0]    out_cols;
  logic [ROWS_W-1:0]   rows_total;
  logic [POS_W-1:0]    pass_len;
  logic [SETTLE_W-1:0] settle_cnt;
  logic [PROD_W-1:0]   prod_h;
  logic [PROD_W-1:0]   prod_w;
  logic [PASS_W-1:0]   prod_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 7'd1;
      frame_height  <= 11'd28;
      frame_width   <= 11'd28;
      window_size   <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_W-1:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_W-1:0];
        REG_WINDOW_SIZE:   window_size   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cnt <= SETTLE_W'(SETTLE_CYCLES);
    end else if (cfg_we) begin
      settle_cnt <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - SETTLE_W'(1);
    end
  end

  assign prod_h    = PROD_W'(cl_height) * PROD_W'(recip(cl_win));
  assign prod_w    = PROD_W'(cl_width) * PROD_W'(recip(cl_win));
  assign prod_pass = PASS_W'(rows_total) * PASS_W'(out_cols);

  // derived values settle after a write through the clamp, quotient, row total and pass length registers
  always_ff @(posedge clk) begin
    cl_count  <= (channel_count == '0) ? 7'd1 :
                 (channel_count > 7'd64) ? 7'd64 : channel_count;
    cl_height <= (frame_height == '0) ? 11'd1 :
                 (frame_height > 11'd1024) ? 11'd1024 : frame_height;
    cl_width  <= (frame_width == '0) ? 11'd1 :
                 (frame_width > 11'd1024) ? 11'd1024 : frame_width;
    cl_win    <= (window_size == '0) ? 4'd1 :
                 (window_size > 4'd8) ? 4'd8 : window_size;
    out_rows   <= prod_h[RECIP_SHIFT +: DIM_W];
    out_cols   <= prod_w[RECIP_SHIFT +: DIM_W];
    rows_total <= ROWS_W'(cl_count) * ROWS_W'(out_rows);
    pass_len   <= (prod_pass > PASS_W'(MAX_OUTPUTS)) ? POS_W'(MAX_OUTPUTS)
                                                     : prod_pass[POS_W-1:0];
  end

  assign cfg.count    = cl_count;
  assign cfg.height   = cl_height;
  assign cfg.width    = cl_width;
  assign cfg.win      = cl_win;
  assign cfg.pass_len = pass_len;
  assign settling     = (settle_cnt != '0);

endmodule

/* design/mpa_front.sv */
module mpa_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  mpa_pkg::cfg_t                    cfg,
  input  logic                             accept,
  input  logic                             opcode,
  input  logic signed [mpa_pkg::VALUE_W-1:0] sample_value,
  output logic                             push,
  output mpa_pkg::item_t                   push_item
);
  import mpa_pkg::*;

  logic [CH_W-1:0]    ch;
  logic [RC_W-1:0]    row;
  logic [RC_W-1:0]    col;
  logic [PX_W-1:0]    px;
  logic [PX_W-1:0]    py;
  logic [COL_AW-1:0]  ow;
  logic [RC_W-1:0]    rb;
  logic [RC_W-1:0]    cb;
  logic [INDEX_W-1:0] flat;
  logic [POS_W-1:0]   pos;
  logic [ARG_AW-1:0]  grad;

  logic [WIN_W-1:0] win_m1;
  logic [DIM_W-1:0] win_ext;
  logic [DIM_W-1:0] win2_ext;
  logic             row_in;
  logic             col_in;
  logic             last_row;
  logic             last_col;
  logic             px_last;
  logic             py_last;
  logic             ch_last;
  logic             col_wrap;
  logic             row_wrap;
  logic             frame_wrap;
  logic             in_grid;
  logic             emit_win;
  logic             fwd;
  logic             bwd;
  logic [POS_W-1:0] g_ext;
  logic [POS_W-1:0] g_next;
  logic             g_ok;
  logic             g_end;

  assign win_m1   = cfg.win - 4'd1;
  assign win_ext  = DIM_W'(cfg.win);
  assign win2_ext = DIM_W'({cfg.win, 1'b0});

  // window blocks that fit fully inside the frame form the grid
  assign row_in   = ({1'b0, rb} + win_ext) <= cfg.height;
  assign col_in   = ({1'b0, cb} + win_ext) <= cfg.width;
  assign last_row = ({1'b0, rb} + win2_ext) > cfg.height;
  assign last_col = ({1'b0, cb} + win2_ext) > cfg.width;
  assign px_last  = ({1'b0, px} == win_m1);
  assign py_last  = ({1'b0, py} == win_m1);
  assign ch_last  = ({1'b0, ch} == cfg.count - 7'd1);

  assign col_wrap   = ({1'b0, col} + 11'd1) >= cfg.width;
  assign row_wrap   = ({1'b0, row} + 11'd1) >= cfg.height;
  assign frame_wrap = col_wrap && row_wrap && ch_last;

  assign fwd      = accept && (opcode == OP_FORWARD);
  assign bwd      = accept && (opcode == OP_BACKWARD);
  assign in_grid  = row_in && col_in;
  assign emit_win = in_grid && px_last && py_last;

  assign g_ext  = {1'b0, grad};
  assign g_next = g_ext + POS_W'(1);
  assign g_ok   = (cfg.pass_len != '0) && (g_ext < cfg.pass_len);
  assign g_end  = (g_next == cfg.pass_len);

  assign push = (fwd && in_grid) || (bwd && g_ok);

  always_comb begin
    push_item.kind     = opcode;
    push_item.value    = sample_value;
    push_item.index    = flat;
    push_item.col      = ow;
    push_item.arg_addr = (opcode == OP_FORWARD) ? pos[ARG_AW-1:0] : grad;
    push_item.arg_ok   = !pos[ARG_AW];
    push_item.px_first = (px == '0);
    push_item.px_last  = px_last;
    push_item.py_first = (py == '0);
    push_item.py_last  = py_last;
    push_item.last     = (opcode == OP_FORWARD) ? (ch_last && last_row && last_col) : g_end;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      ch   <= '0;
      row  <= '0;
      col  <= '0;
      px   <= '0;
      py   <= '0;
      ow   <= '0;
      rb   <= '0;
      cb   <= '0;
      flat <= '0;
      pos  <= '0;
    end else if (fwd) begin
      if (col_wrap) begin
        col <= '0;
        px  <= '0;
        ow  <= '0;
        cb  <= '0;
        if (row_wrap) begin
          row <= '0;
          py  <= '0;
          rb  <= '0;
          ch  <= ch_last ? '0 : ch + CH_W'(1);
        end else begin
          row <= row + RC_W'(1);
          if (py_last) begin
            py <= '0;
            rb <= row + RC_W'(1);
          end else begin
            py <= py + PX_W'(1);
          end
        end
      end else begin
        col <= col + RC_W'(1);
        if (px_last) begin
          px <= '0;
          ow <= ow + COL_AW'(1);
          cb <= col + RC_W'(1);
        end else begin
          px <= px + PX_W'(1);
        end
      end
      if (frame_wrap) begin
        flat <= '0;
        pos  <= '0;
      end else begin
        flat <= flat + INDEX_W'(1);
        // saturates once past the storable output range
        if (emit_win && !pos[ARG_AW]) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      grad <= '0;
    end else if (bwd) begin
      if (!g_ok || (g_next >= cfg.pass_len)) begin
        grad <= '0;
      end else begin
        grad <= g_next[ARG_AW-1:0];
      end
    end
  end

endmodule

/* design/mpa_fifo.sv */
module mpa_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpa_pkg::item_t push_item,
  input  logic           pop,
  output mpa_pkg::item_t head,
  output logic           not_empty,
  output logic           not_full
);
  import mpa_pkg::*;

  localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

  item_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [CNT_BITS-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_BITS'(1);
        2'b01:   fill <= fill - CNT_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

  assign head      = slots[rd_ptr];
  assign not_empty = (fill != '0);
  assign not_full  = (fill != CNT_BITS'(FIFO_DEPTH));

endmodule

/* design/mpa_back.sv */
module mpa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  mpa_pkg::item_t head,
  output logic           pop,
  output logic           clearing,
  mpa_out_if.source      out_ch
);
  import mpa_pkg::*;

  localparam int COL_DEPTH = MAX_OUT_WIDTH;
  localparam int ARG_WW    = INDEX_W + 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_val;
    logic [INDEX_W-1:0]        index;
  } run_t;

  run_t              col_mem [COL_DEPTH];
  logic [ARG_WW-1:0] arg_mem [MAX_OUTPUTS];

  run_t              col_rd;
  logic [ARG_WW-1:0] arg_rd;

  logic              s_v;
  item_t             s_item;
  run_t              seg;

  logic              cw_v;
  logic [COL_AW-1:0] cw_addr;
  run_t              cw_data;
  logic              aw_v;
  logic [ARG_AW-1:0] aw_addr;
  logic [ARG_WW-1:0] aw_data;

  logic [ARG_AW-1:0] clr_addr;

  logic                      o_valid;
  logic                      o_kind;
  logic signed [VALUE_W-1:0] o_value;
  logic [INDEX_W-1:0]        o_index;
  logic                      o_end;

  run_t              col_prev;
  run_t              prior;
  run_t              cur;
  logic              take_new;
  logic [ARG_WW-1:0] arg_word;
  logic              is_fwd;
  logic              emit;
  logic              s_fire;
  logic              col_we;
  logic              store_we;
  logic              arg_we;
  logic [ARG_AW-1:0] arg_waddr;
  logic [ARG_WW-1:0] arg_wdata;

  // last write bypasses the registered read of the same entry
  assign col_prev = (cw_v && (cw_addr == s_item.col)) ? cw_data : col_rd;
  assign arg_word = (aw_v && (aw_addr == s_item.arg_addr)) ? aw_data : arg_rd;

  assign is_fwd   = (s_item.kind == OP_FORWARD);
  assign prior    = s_item.px_first ? col_prev : seg;
  assign take_new = (s_item.px_first && s_item.py_first) || (s_item.value > prior.max_val);
  assign cur      = take_new ? run_t'{max_val: s_item.value, index: s_item.index} : prior;

  assign emit   = is_fwd ? (s_item.px_last && s_item.py_last) : arg_word[INDEX_W];
  assign s_fire = s_v && (!emit || !o_valid || out_ch.ready);
  assign pop    = head_valid && !clearing && (!s_v || s_fire);

  assign col_we   = s_fire && is_fwd && s_item.px_last && !s_item.py_last;
  assign store_we = s_fire && is_fwd && s_item.px_last && s_item.py_last && s_item.arg_ok;
  assign arg_we   = clearing || store_we;
  assign arg_waddr = clearing ? clr_addr : s_item.arg_addr;
  assign arg_wdata = clearing ? '0 : {1'b1, cur.index};

  always_ff @(posedge clk) begin
    if (pop) begin
      col_rd <= col_mem[head.col];
    end
    if (col_we) begin
      col_mem[s_item.col] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      arg_rd <= arg_mem[head.arg_addr];
    end
    if (arg_we) begin
      arg_mem[arg_waddr] <= arg_wdata;
    end
  end

  // clearing pass over the argmax store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ARG_AW'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v  <= 1'b0;
      cw_v <= 1'b0;
      aw_v <= 1'b0;
    end else begin
      if (pop) begin
        s_v <= 1'b1;
      end else if (s_fire) begin
        s_v <= 1'b0;
      end
      if (col_we) begin
        cw_v <= 1'b1;
      end
      if (store_we) begin
        aw_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s_item <= head;
    end
    if (s_fire && is_fwd) begin
      seg <= cur;
    end
    if (col_we) begin
      cw_addr <= s_item.col;
      cw_data <= cur;
    end
    if (store_we) begin
      aw_addr <= s_item.arg_addr;
      aw_data <= arg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_fire && emit) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && emit) begin
      o_kind  <= is_fwd ? KIND_MAX : KIND_GRAD;
      o_value <= is_fwd ? cur.max_val : s_item.value;
      o_index <= is_fwd ? cur.index : arg_word[INDEX_W-1:0];
      o_end   <= s_item.last;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.result_kind  = o_kind;
  assign out_ch.result_value = o_value;
  assign out_ch.input_index  = o_index;
  assign out_ch.pass_end     = o_end;

endmodule

/* design/max_pool_2d_argmax_unit.sv */
// Non-overlapping 2D max pooling with argmax routing. Forward samples
// (opcode 0) stream in channel, row, column order; each finished window
// gives its maximum and the flat input index of that maximum, and the index
// is kept per output position. Backward gradients (opcode 1) are routed to
// the stored indices in output order. One item is accepted per clock cycle
// sustained while the sink is ready; a result goes from the FIFO through the
// stage register to the output register. The column store is read for every
// item and written at the end of each window row but the last, through
// separate read and write ports, so both fit in the same cycle; a bypass
// covers back-to-back access to one column.
// After reset the argmax store is swept clear, one entry a cycle, and no
// item is accepted during the sweep. After each configuration write input
// ready stays low while the derived geometry settles.
module max_pool_2d_argmax_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data,
  mpa_in_if.sink                         in_ch,
  mpa_out_if.source                      out_ch
);
  import mpa_pkg::*;

  cfg_t  cfg;
  logic  settling;
  logic  clearing;
  logic  accept;
  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  not_empty;
  logic  not_full;

  assign in_ch.ready = not_full && !settling && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;

  mpa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .settling  (settling)
  );

  mpa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg          (cfg),
    .accept       (accept),
    .opcode       (in_ch.opcode),
    .sample_value (in_ch.sample_value),
    .push         (push),
    .push_item    (push_item)
  );

  mpa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .not_full  (not_full)
  );

  mpa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .out_ch     (out_ch)
  );

endmodule

/* tb/sv/pool_result_checker.sv */
module pool_result_checker
  import mpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mpa_in_if                     in_ch,
  mpa_out_if                    out_ch,
  output int                    failures,
  output int                    pending,
  output int                    maxima_seen,
  output int                    gradients_seen
);

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic                      last;
  } pool_result_t;

  logic [CNT_W-1:0] channels_raw;
  logic [DIM_W-1:0] height_raw;
  logic [DIM_W-1:0] width_raw;
  logic [WIN_W-1:0] window_raw;

  logic signed [VALUE_W-1:0] col_max [MAX_OUT_WIDTH];
  logic [INDEX_W-1:0]        col_arg [MAX_OUT_WIDTH];
  logic [INDEX_W-1:0]        argmax_idx [MAX_OUTPUTS];
  bit                        argmax_ok [MAX_OUTPUTS];

  int unsigned ch_pos, row_pos, col_pos, grad_pos;

  pool_result_t due_results [$];

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // advances the pooling state by one item, returns 1 when it gives a result
  function automatic bit pool_and_route(input logic op, input logic signed [VALUE_W-1:0] v,
                                        output pool_result_t res);
    int unsigned chans, rows, cols, win, oh_n, ow_n, ow, oh, py, px, pass_len;
    longint unsigned flat, slot;
    bit produced;
    chans = clamp_to(channels_raw, 1, 64);
    rows  = clamp_to(height_raw, 1, 1024);
    cols  = clamp_to(width_raw, 1, 1024);
    win   = clamp_to(window_raw, 1, 8);
    oh_n  = rows / win;
    ow_n  = cols / win;
    if (ow_n > MAX_OUT_WIDTH) ow_n = MAX_OUT_WIDTH;
    produced = 1'b0;
    res = '0;
    if (op == OP_FORWARD) begin
      if (row_pos < oh_n * win && col_pos < ow_n * win) begin
        ow = col_pos / win;
        oh = row_pos / win;
        py = row_pos % win;
        px = col_pos % win;
        flat = (longint'(ch_pos) * rows + row_pos) * cols + col_pos;
        // window start always overwrites, later samples only on strictly greater
        if ((py == 0 && px == 0) || v > col_max[ow]) begin
          col_max[ow] = v;
          col_arg[ow] = flat[INDEX_W-1:0];
        end
        if (py == win - 1 && px == win - 1) begin
          slot = (longint'(ch_pos) * oh_n + oh) * ow_n + ow;
          if (slot < MAX_OUTPUTS) begin
            argmax_idx[slot] = col_arg[ow];
            argmax_ok[slot]  = 1'b1;
          end
          res.kind  = KIND_MAX;
          res.value = col_max[ow];
          res.index = col_arg[ow];
          res.last  = (ch_pos == chans - 1 && oh == oh_n - 1 && ow == ow_n - 1);
          produced  = 1'b1;
        end
      end
      col_pos++;
      if (col_pos >= cols) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= rows) begin
          row_pos = 0;
          ch_pos++;
          if (ch_pos >= chans) ch_pos = 0;
        end
      end
    end else begin
      pass_len = chans * oh_n * ow_n;
      if (pass_len > MAX_OUTPUTS) pass_len = MAX_OUTPUTS;
      if (pass_len == 0 || grad_pos >= pass_len) begin
        grad_pos = 0;
        return 1'b0;
      end
      if (argmax_ok[grad_pos]) begin
        res.kind  = KIND_GRAD;
        res.value = v;
        res.index = argmax_idx[grad_pos];
        res.last  = (grad_pos + 1 == pass_len);
        produced  = 1'b1;
      end
      grad_pos++;
      if (grad_pos >= pass_len) grad_pos = 0;
    end
    return produced;
  endfunction

  task automatic note_failure(input string what, input pool_result_t want,
                              input pool_result_t seen);
    failures++;
    if (failures <= 10)
      $display("%0t %s: want kind=%0d value=%0d index=%0d end=%0d, got kind=%0d value=%0d %s",
               $time, what, want.kind, want.value, want.index, want.last, seen.kind,
               seen.value, $sformatf("index=%0d end=%0d", seen.index, seen.last));
  endtask

  always @(posedge clk) begin
    pool_result_t want, seen, fresh;
    if (rst) begin
      channels_raw = 7'd1;
      height_raw   = 11'd28;
      width_raw    = 11'd28;
      window_raw   = 4'd2;
      foreach (argmax_ok[i]) argmax_ok[i] = 1'b0;
      ch_pos = 0;
      row_pos = 0;
      col_pos = 0;
      grad_pos = 0;
      due_results.delete();
      failures = 0;
      maxima_seen = 0;
      gradients_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: channels_raw = cfg_data[CNT_W-1:0];
          REG_FRAME_HEIGHT:  height_raw   = cfg_data[DIM_W-1:0];
          REG_FRAME_WIDTH:   width_raw    = cfg_data[DIM_W-1:0];
          REG_WINDOW_SIZE:   window_raw   = cfg_data[WIN_W-1:0];
          default: ;
        endcase
        ch_pos = 0;
        row_pos = 0;
        col_pos = 0;
        grad_pos = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.kind  = out_ch.result_kind;
        seen.value = out_ch.result_value;
        seen.index = out_ch.input_index;
        seen.last  = out_ch.pass_end;
        if (seen.kind == KIND_GRAD) gradients_seen++;
        else maxima_seen++;
        if (due_results.size() == 0) begin
          note_failure("result with nothing expected", '0, seen);
        end else begin
          want = due_results.pop_front();
          if (seen.kind !== want.kind || seen.value !== want.value ||
              seen.index !== want.index || seen.last !== want.last)
            note_failure("result mismatch", want, seen);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (pool_and_route(in_ch.opcode, in_ch.sample_value, fresh))
          due_results.push_back(fresh);
      end
    end
    pending <= due_results.size();
  end

endmodule

/* tb/sv/max_pool_2d_argmax_unit_tb.sv */
module max_pool_2d_argmax_unit_tb;
  import mpa_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mpa_in_if  in_ch ();
  mpa_out_if out_ch ();

  int failures, pending, maxima_seen, gradients_seen;
  int n_sent, n_settings;
  bit quiet;
  bit hold_req;

  max_pool_2d_argmax_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pool_result_checker i_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .failures       (failures),
    .pending        (pending),
    .maxima_seen    (maxima_seen),
    .gradients_seen (gradients_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // small values make ties likely, full-scale values hit the extremes
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return VALUE_W'($urandom_range(0, 4)) - VALUE_W'(2);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sample_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // let every outstanding result arrive, then cover items still in flight
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] s);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold so the block backs up and drops input ready
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (64) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned c, h, w, s, oh, ow, frame, pass, mode, base;
    logic [CFG_DATA_W-1:0] c_raw, s_raw;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_CHANNEL_COUNT;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_FORWARD;
    in_ch.sample_value = '0;
    quiet              = 1'b0;
    hold_req           = 1'b0;
    n_sent             = 0;
    n_settings         = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // gradient before any argmax is stored, reset geometry
    send_item(OP_BACKWARD, 16'sh1234);
    drain();

    // single 2x2 window: all-equal minimum, then earliest of two maxima
    configure(1, 2, 2, 2);
    repeat (4) send_item(OP_FORWARD, 16'sh8000);
    send_item(OP_FORWARD, 16'sh0000);
    send_item(OP_FORWARD, 16'sh7FFF);
    send_item(OP_FORWARD, 16'sh0064);
    send_item(OP_FORWARD, 16'sh7FFF);
    send_item(OP_BACKWARD, 16'sh7FFF);
    send_item(OP_BACKWARD, 16'sh8000);
    drain();

    // last row and column fall outside the window grid
    configure(1, 3, 3, 2);
    repeat (9) send_item(OP_FORWARD, pick_value());
    drain();

    // window larger than the frame: nothing comes out
    configure(1, 3, 3, 8);
    send_item(OP_FORWARD, 16'sh0101);
    send_item(OP_BACKWARD, 16'sh0202);
    drain();

    // out-of-range register values saturate
    configure(0, 2047, 2047, 15);
    send_item(OP_FORWARD, 16'sh7FFF);
    send_item(OP_FORWARD, 16'sh8000);
    send_item(OP_BACKWARD, 16'sh00FF);
    drain();

    // output backpressure while the sender keeps offering
    configure(1, 8, 8, 1);
    hold_req = 1'b1;
    repeat (64) send_item(OP_FORWARD, pick_value());
    drain();

    base = n_sent;
    c = 1;
    h = 8;
    w = 8;
    s = 1;
    while (n_sent - base < 340) begin
      drain();
      if (n_sent - base > 270) quiet = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        c = $urandom_range(1, 3);
        h = $urandom_range(1, 6);
        w = $urandom_range(1, 6);
        s = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        c_raw = (c == 1 && $urandom_range(0, 1)) ? '0 : CFG_DATA_W'(c);
        s_raw = (s == 1 && $urandom_range(0, 1)) ? '0 : CFG_DATA_W'(s);
        if (s == 8) s_raw = CFG_DATA_W'($urandom_range(8, 15));
        configure(c_raw, CFG_DATA_W'(h), CFG_DATA_W'(w), s_raw);
      end
      oh    = h / s;
      ow    = w / s;
      frame = c * h * w;
      pass  = c * oh * ow;
      mode  = $urandom_range(0, 9);
      if (mode < 7) begin
        repeat (frame) send_item(OP_FORWARD, pick_value());
        repeat (pass + $urandom_range(0, 1)) send_item(OP_BACKWARD, pick_value());
      end else if (mode < 9) begin
        repeat ($urandom_range(10, 40)) send_item(1'($urandom_range(0, 1)), pick_value());
      end else begin
        // frame cut short, then a pass over what is stored
        repeat ($urandom_range(1, frame)) send_item(OP_FORWARD, pick_value());
        repeat (pass) send_item(OP_BACKWARD, pick_value());
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("sent %0d items over %0d geometry settings; checked %0d maxima, %0d gradients",
             n_sent, n_settings, maxima_seen, gradients_seen);
    $display("included ties, grid edges, empty grids, saturated registers, output stalls");
    if (failures == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
design/mpa_pkg.sv
design/mpa_in_if.sv
design/mpa_out_if.sv
design/mpa_cfg.sv
design/mpa_front.sv
design/mpa_fifo.sv
design/mpa_back.sv
design/max_pool_2d_argmax_unit.sv
tb/sv/pool_result_checker.sv
tb/sv/max_pool_2d_argmax_unit_tb.sv
